FILE: hw/rtl/srsw_pkg.sv
`timescale 1ns / 1ps

package srsw_pkg;

	localparam int SEQ_BITS = 8;
	localparam int MODULUS = 1 << SEQ_BITS;
	localparam int WIN_BITS = 8;
	localparam int PAY_BITS = 64;
	localparam int STATUS_BITS = 3;
	localparam int FUNC_BITS = 2;

	localparam logic [WIN_BITS-1:0] WIN_RESET = 8'd4;

	typedef logic [SEQ_BITS-1:0] seq_t;

	localparam logic [FUNC_BITS-1:0] FUNC_SEND = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_ACK = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_TIMEOUT = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_SENT = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_ACK_TAKEN = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_ACK_OUTSIDE = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_ACK_CORRUPT = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_RESENT = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic exec;
		logic slide;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_slide;
		logic slide_more;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// Selective-repeat ARQ sender window.
// Input stream (s_*): one transfer per event; s_tuser gives the kind (send, acknowledgement,
// timer expiry), s_tdata the sequence number, the checksum flag and the payload word.
// Output stream (m_*): exactly one result transfer per input transfer, in order; m_tuser
// holds the status code, m_tdata the frame to transmit, the timer request and the window
// state after the event.
// cfg_wr_en / cfg_wr_data write the window length; write it only while the block is idle.
// An item is taken into the input registers and its result is then registered into the
// output register once that register is free. An acknowledgement of the base frame first
// walks the acked bitmap, one memory read per cycle, passing the further acked frames
// (fewer than the window length) before its result is registered.
// One item is in work at a time.
// The next item is taken while a result still waits on m_tready; a stalled receiver holds
// the block only when the following result is ready to be written.
// Reset clears base and next sequence numbers, sets the window length to 4 and empties the
// output register. The frame store and acked bitmap are not cleared; every bitmap entry
// that is used is written by its send first; a timer expiry may read an unwritten frame.

module selective_repeat_sender_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // sequence_req[7:0], checksum_ok[8], payload[72:9], zero
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// tx_valid[0], tx_seq[8:1], tx_payload[72:9], timer_start[73], timer_stop[74],
	// timer_seq[82:75], window_full[83], window_base[91:84], zero
	output logic [95:0] m_tdata,
	output logic [2:0]  m_tuser   // status[2:0]
);
	import srsw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic [STATUS_BITS-1:0] status;
	logic tx_valid, timer_start, timer_stop, window_full;
	seq_t tx_seq, timer_seq, window_base;
	logic [PAY_BITS-1:0] tx_payload;

	srsw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srsw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_func         (s_tuser),
		.in_seq          (s_tdata[7:0]),
		.in_ok           (s_tdata[8]),
		.in_payload      (s_tdata[72:9]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (status),
		.out_tx_valid    (tx_valid),
		.out_tx_seq      (tx_seq),
		.out_tx_payload  (tx_payload),
		.out_timer_start (timer_start),
		.out_timer_stop  (timer_stop),
		.out_timer_seq   (timer_seq),
		.out_window_full (window_full),
		.out_window_base (window_base)
	);

	assign m_tuser = status;
	assign m_tdata = {4'b0000, window_base, window_full, timer_seq, timer_stop, timer_start,
		tx_payload, tx_seq, tx_valid};

endmodule

FILE: hw/rtl/srsw_ctrl.sv
`timescale 1ns / 1ps

module srsw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  srsw_pkg::sts_t sts,
	output srsw_pkg::cmd_t cmd
);
	import srsw_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SLIDE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d = sts.start_slide ? S_SLIDE : S_IDLE;
				end
			end
			S_SLIDE: begin
				if (sts.slide_more) begin
					cmd.slide = 1'b1;
				end else if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/srsw_dp.sv
`timescale 1ns / 1ps

module srsw_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srsw_pkg::cmd_t                      cmd,
	output srsw_pkg::sts_t                      sts,
	input  logic                                cfg_wr_en,
	input  logic [srsw_pkg::WIN_BITS-1:0]       cfg_wr_data,
	input  logic [srsw_pkg::FUNC_BITS-1:0]      in_func,
	input  srsw_pkg::seq_t                      in_seq,
	input  logic                                in_ok,
	input  logic [srsw_pkg::PAY_BITS-1:0]       in_payload,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [srsw_pkg::STATUS_BITS-1:0]    out_status,
	output logic                                out_tx_valid,
	output srsw_pkg::seq_t                      out_tx_seq,
	output logic [srsw_pkg::PAY_BITS-1:0]       out_tx_payload,
	output logic                                out_timer_start,
	output logic                                out_timer_stop,
	output srsw_pkg::seq_t                      out_timer_seq,
	output logic                                out_window_full,
	output srsw_pkg::seq_t                      out_window_base
);
	import srsw_pkg::*;

	seq_t base_q, next_q, base_d, next_d;
	logic [WIN_BITS-1:0] win_q;

	logic [FUNC_BITS-1:0] func_q;
	seq_t seq_q;
	logic ok_q;
	logic [PAY_BITS-1:0] pay_q;

	logic [PAY_BITS-1:0] frame_mem [MODULUS];
	logic ack_mem [MODULUS];
	logic [PAY_BITS-1:0] rd_frame_q;
	logic rd_ack_q;

	logic frame_we, ack_we, ack_wdata, rd_en;
	seq_t ack_waddr, rd_addr;

	logic in_window, full_now, full_d, load_out;
	seq_t span, offset;

	logic [STATUS_BITS-1:0] status_c;
	logic tx_valid_c, start_c, stop_c;
	seq_t tx_seq_c, timer_seq_c;
	logic [PAY_BITS-1:0] tx_payload_c;

	assign full_now = next_q == seq_t'(base_q + win_q);
	assign span = next_q - base_q;
	assign offset = seq_q - base_q;
	// The window is the run of numbers from base up to next; empty when they meet.
	assign in_window = offset < span;

	assign sts.start_slide = (func_q == FUNC_ACK) && ok_q && in_window && (seq_q == base_q);
	assign sts.slide_more = (base_q != next_q) && rd_ack_q;
	assign sts.out_free = !out_valid || out_ready;

	always_comb begin
		status_c = ST_ACK_CORRUPT;
		tx_valid_c = 1'b0;
		tx_seq_c = '0;
		tx_payload_c = '0;
		start_c = 1'b0;
		stop_c = 1'b0;
		timer_seq_c = '0;
		frame_we = 1'b0;
		ack_we = 1'b0;
		ack_wdata = 1'b0;
		ack_waddr = next_q;
		base_d = base_q;
		next_d = next_q;
		if (cmd.exec) begin
			unique case (func_q)
				FUNC_SEND: begin
					if (full_now) begin
						status_c = ST_FULL;
					end else begin
						status_c = ST_SENT;
						frame_we = 1'b1;
						ack_we = 1'b1;
						tx_valid_c = 1'b1;
						tx_seq_c = next_q;
						tx_payload_c = pay_q;
						start_c = 1'b1;
						timer_seq_c = next_q;
						next_d = next_q + seq_t'(1);
					end
				end
				FUNC_ACK: begin
					if (!ok_q) begin
						status_c = ST_ACK_CORRUPT;
					end else if (!in_window) begin
						status_c = ST_ACK_OUTSIDE;
					end else begin
						status_c = ST_ACK_TAKEN;
						if (!rd_ack_q) begin
							ack_we = 1'b1;
							ack_wdata = 1'b1;
							ack_waddr = seq_q;
							stop_c = 1'b1;
							timer_seq_c = seq_q;
						end
						// The acked frame at base is passed at once; the rest of the
						// run is walked one entry a cycle.
						if (seq_q == base_q) begin
							base_d = base_q + seq_t'(1);
						end
					end
				end
				FUNC_TIMEOUT: begin
					status_c = ST_RESENT;
					tx_valid_c = 1'b1;
					tx_seq_c = seq_q;
					tx_payload_c = rd_frame_q;
					start_c = 1'b1;
					timer_seq_c = seq_q;
				end
				default: begin
					status_c = ST_ACK_CORRUPT;
				end
			endcase
		end else if (cmd.slide) begin
			base_d = base_q + seq_t'(1);
		end
	end

	assign full_d = next_d == seq_t'(base_d + win_q);
	assign load_out = (cmd.exec && !sts.start_slide) || cmd.finish;

	assign rd_en = cmd.take || cmd.exec || cmd.slide;
	assign rd_addr = cmd.take ? in_seq : seq_t'(base_q + seq_t'(1));

	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[next_q] <= pay_q;
		end
		if (ack_we) begin
			ack_mem[ack_waddr] <= ack_wdata;
		end
		if (cmd.take) begin
			rd_frame_q <= frame_mem[in_seq];
		end
		if (rd_en) begin
			rd_ack_q <= ack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= in_func;
			seq_q <= in_seq;
			ok_q <= in_ok;
			pay_q <= in_payload;
		end
		if (cmd.exec) begin
			out_status <= status_c;
			out_tx_valid <= tx_valid_c;
			out_tx_seq <= tx_seq_c;
			out_tx_payload <= tx_payload_c;
			out_timer_start <= start_c;
			out_timer_stop <= stop_c;
			out_timer_seq <= timer_seq_c;
		end
		if (load_out) begin
			out_window_full <= full_d;
			out_window_base <= base_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			next_q <= '0;
			win_q <= WIN_RESET;
			out_valid <= 1'b0;
		end else begin
			base_q <= base_d;
			next_q <= next_d;
			if (cfg_wr_en) begin
				win_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/srsw_chk.sv
`timescale 1ns / 1ps

module srsw_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import srsw_pkg::*;

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only one item is in work: a transfer in closes the input for the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// Frames go out exactly for sends and resends, always with a timer start.
	a_tx_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == ((m_tuser == ST_SENT) || (m_tuser == ST_RESENT)))
			&& (m_tdata[73] == m_tdata[0]))
		else $error("transmit flag does not match status");

	// A timer is never started and stopped by the same result.
	a_timer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[73] && m_tdata[74]))
		else $error("timer start and stop together");

	// Idle fields read as zero.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] && !m_tdata[73] && !m_tdata[74]
			|-> (m_tdata[72:1] == '0) && (m_tdata[82:75] == '0))
		else $error("unused result fields not cleared");

endmodule

bind selective_repeat_sender_window srsw_chk u_srsw_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
